// File: rtl/fct_pkg.sv
`timescale 1ns / 1ps
package fct_pkg;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_POINT  = 3'd1;
  localparam logic [2:0] CMD_SPHERE = 3'd2;
  localparam logic [2:0] CMD_CUBE   = 3'd3;
  localparam logic [2:0] CMD_BOX    = 3'd4;

  // width of the exact plane distance, products are Q.46
  localparam int SUM_W = 67;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         plane_index;
    logic signed [31:0] plane_a;
    logic signed [31:0] plane_b;
    logic signed [31:0] plane_c;
    logic signed [31:0] plane_d;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        extent_z;
    logic               vis;
  } item_t;

  function automatic logic is_test(input logic [2:0] cmd);
    is_test = (cmd == CMD_POINT) || (cmd == CMD_SPHERE) ||
              (cmd == CMD_CUBE) || (cmd == CMD_BOX);
  endfunction

endpackage

// File: rtl/fct_if.sv
`timescale 1ns / 1ps
interface fct_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         plane_index;
  logic signed [31:0] plane_a;
  logic signed [31:0] plane_b;
  logic signed [31:0] plane_c;
  logic signed [31:0] plane_d;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        extent_x;
  logic [30:0]        extent_y;
  logic [30:0]        extent_z;

  modport source (
    output valid, command, plane_index, plane_a, plane_b, plane_c, plane_d,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, command, plane_index, plane_a, plane_b, plane_c, plane_d,
           center_x, center_y, center_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// File: rtl/fct_cell.sv
`timescale 1ns / 1ps
module fct_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  fct_pkg::item_t  in_item,
  output logic            out_vld,
  output fct_pkg::item_t  out_item
);
  import fct_pkg::*;

  // plane held by this cell
  logic signed [31:0] a_r, b_r, c_r, d_r;

  // stage 1: products
  logic               s1_vld_r;
  item_t              s1_item_r;
  logic signed [63:0] pa_r, pb_r, pc_r;
  logic [62:0]        qa_r, qb_r, qc_r;
  logic signed [31:0] dt_r;

  // stage 2: partial sums
  logic                    s2_vld_r;
  item_t                   s2_item_r;
  logic signed [SUM_W-1:0] sum1_r, sum2_r;

  // stage 3: verdict
  logic  out_vld_r;
  item_t out_item_r;

  logic [31:0]             abs_a, abs_b, abs_c;
  logic signed [63:0]      pa_nxt, pb_nxt, pc_nxt;
  logic [62:0]             qa_nxt, qb_nxt, qc_nxt;
  logic signed [SUM_W-1:0] sum1_nxt, sum2_nxt, total;
  logic                    load_hit;
  item_t                   out_item_nxt;

  assign load_hit = in_vld && (in_item.command == CMD_LOAD) &&
                    (int'(in_item.plane_index) == CELL_IDX);

  always_comb begin
    abs_a  = a_r[31] ? (~a_r + 32'd1) : a_r;
    abs_b  = b_r[31] ? (~b_r + 32'd1) : b_r;
    abs_c  = c_r[31] ? (~c_r + 32'd1) : c_r;
    pa_nxt = 64'(a_r) * 64'(in_item.center_x);
    pb_nxt = 64'(b_r) * 64'(in_item.center_y);
    pc_nxt = 64'(c_r) * 64'(in_item.center_z);
    qa_nxt = 63'(abs_a) * 63'(in_item.extent_x);
    qb_nxt = 63'(abs_b) * 63'(in_item.extent_y);
    qc_nxt = 63'(abs_c) * 63'(in_item.extent_z);
  end

  always_comb begin
    sum1_nxt = SUM_W'(pa_r) + SUM_W'(pb_r) + SUM_W'(pc_r) + (SUM_W'(dt_r) <<< 30);
    case (s1_item_r.command)
      CMD_SPHERE: sum2_nxt = SUM_W'({s1_item_r.extent_x, 30'd0});
      CMD_CUBE,
      CMD_BOX:    sum2_nxt = SUM_W'(qa_r) + SUM_W'(qb_r) + SUM_W'(qc_r);
      default:    sum2_nxt = '0;
    endcase
  end

  always_comb begin
    total        = sum1_r + sum2_r;
    out_item_nxt = s2_item_r;
    if (is_test(s2_item_r.command) && total[SUM_W-1]) begin
      out_item_nxt.vis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else if (en && load_hit) begin
      a_r <= in_item.plane_a;
      b_r <= in_item.plane_b;
      c_r <= in_item.plane_c;
      d_r <= in_item.plane_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r  <= in_item;
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      pc_r       <= pc_nxt;
      qa_r       <= qa_nxt;
      qb_r       <= qb_nxt;
      qc_r       <= qc_nxt;
      dt_r       <= d_r;
      s2_item_r  <= s1_item_r;
      sum1_r     <= sum1_nxt;
      sum2_r     <= sum2_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

// File: rtl/frustum_cull_test_core.sv
`timescale 1ns / 1ps
// an input transaction passes through the NUM_PLANES plane cells in turn, one pass per plane cell
// throughput: one item per cycle while no result is stalled; each cell holds one plane and three pipeline stages
// a stalled result freezes the whole cell chain until it is taken
// loads and unused commands travel the chain but produce no result transaction
// reset (synchronous, rst_n low) zeroes all planes and empties the chain
module frustum_cull_test_core #(
  parameter int NUM_PLANES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  fct_in_if.sink     in_chan,
  fct_out_if.source  out_chan
);
  import fct_pkg::*;

  logic  vld  [NUM_PLANES+1];
  item_t item [NUM_PLANES+1];
  logic  en;
  logic  accept;

  assign out_chan.valid   = vld[NUM_PLANES] && is_test(item[NUM_PLANES].command);
  assign out_chan.visible = item[NUM_PLANES].vis;
  assign en               = !out_chan.valid || out_chan.ready;
  assign in_chan.ready    = en;
  assign accept           = in_chan.valid && en;

  always_comb begin
    vld[0]              = accept;
    item[0].command     = in_chan.command;
    item[0].plane_index = in_chan.plane_index;
    item[0].plane_a     = in_chan.plane_a;
    item[0].plane_b     = in_chan.plane_b;
    item[0].plane_c     = in_chan.plane_c;
    item[0].plane_d     = in_chan.plane_d;
    item[0].center_x    = in_chan.center_x;
    item[0].center_y    = in_chan.center_y;
    item[0].center_z    = in_chan.center_z;
    item[0].extent_x    = in_chan.extent_x;
    item[0].vis         = 1'b1;
    // a cube uses its one half size on all three axes
    if (in_chan.command == CMD_CUBE) begin
      item[0].extent_y = in_chan.extent_x;
      item[0].extent_z = in_chan.extent_x;
    end else begin
      item[0].extent_y = in_chan.extent_y;
      item[0].extent_z = in_chan.extent_z;
    end
  end

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    fct_cell #(.CELL_IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[g]),
      .in_item  (item[g]),
      .out_vld  (vld[g+1]),
      .out_item (item[g+1])
    );
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while result stalled");

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld[NUM_PLANES]) && $stable(item[NUM_PLANES].vis))
    else $error("chain moved during stall");

  a_first_cell_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en && accept && is_test(in_chan.command) |=> g_cell[0].u_cell.s1_vld_r)
    else $error("accepted transaction lost in first cell");

endmodule
